[rtl/mscs_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and helpers for the MPEG start code scanner.
// No dependencies; imported by every module of the block.
package mscs_pkg;

    localparam int QueueDepthDefault = 4;

    // start code values with a meaning of their own
    localparam logic [7:0] CODE_PACK    = 8'hba;
    localparam logic [7:0] CODE_SYSTEM  = 8'hbb;
    localparam logic [7:0] CODE_SEQ     = 8'hb3;
    localparam logic [7:0] CODE_GOP     = 8'hb8;
    localparam logic [7:0] CODE_PICTURE = 8'h00;
    localparam logic [7:0] CODE_SLICE_LO = 8'h01;
    localparam logic [7:0] CODE_SLICE_HI = 8'haf;
    localparam logic [7:0] CODE_AUDIO_LO = 8'hc0;
    localparam logic [7:0] CODE_AUDIO_HI = 8'hdf;
    localparam logic [7:0] CODE_VIDEO_LO = 8'he0;
    localparam logic [7:0] CODE_VIDEO_HI = 8'hef;
    localparam logic [7:0] PREFIX_END   = 8'h01;

    localparam logic [2:0] SEQ_HDR_BYTES = 3'd4;
    localparam logic [2:0] PIC_HDR_BYTES = 3'd2;

    // unit kinds as reported on the result channel
    localparam logic [3:0] KIND_PACK    = 4'd0;
    localparam logic [3:0] KIND_SYSTEM  = 4'd1;
    localparam logic [3:0] KIND_SEQ     = 4'd2;
    localparam logic [3:0] KIND_GOP     = 4'd3;
    localparam logic [3:0] KIND_PICTURE = 4'd4;
    localparam logic [3:0] KIND_SLICE   = 4'd5;
    localparam logic [3:0] KIND_AUDIO   = 4'd6;
    localparam logic [3:0] KIND_VIDEO   = 4'd7;
    localparam logic [3:0] KIND_UNKNOWN = 4'd8;

    // role of a byte handed from the front to the back
    typedef enum logic [1:0] {
        TOK_CODE_DONE,  // code byte that completes a unit by itself
        TOK_CODE_HDR,   // code byte that opens a header capture
        TOK_HDR,        // header byte, more to follow
        TOK_LAST        // last header byte, completes the unit
    } tok_tag_t;

    typedef struct packed {
        tok_tag_t    tag;
        logic [7:0]  data;
    } token_t;

    function automatic logic [3:0] classify(input logic [7:0] code);
        logic [3:0] kind;
        begin
            if (code == CODE_PACK)
                kind = KIND_PACK;
            else if (code == CODE_SYSTEM)
                kind = KIND_SYSTEM;
            else if (code == CODE_SEQ)
                kind = KIND_SEQ;
            else if (code == CODE_GOP)
                kind = KIND_GOP;
            else if (code == CODE_PICTURE)
                kind = KIND_PICTURE;
            else if (code >= CODE_SLICE_LO && code <= CODE_SLICE_HI)
                kind = KIND_SLICE;
            else if (code >= CODE_AUDIO_LO && code <= CODE_AUDIO_HI)
                kind = KIND_AUDIO;
            else if (code >= CODE_VIDEO_LO && code <= CODE_VIDEO_HI)
                kind = KIND_VIDEO;
            else
                kind = KIND_UNKNOWN;
            return kind;
        end
    endfunction

endpackage

[rtl/mscs_front.sv]
`timescale 1ns / 1ps
// Front end: prefix search and byte tagging, one byte per cycle while accept is high.
// Depends on mscs_pkg; pushes tagged bytes into the token queue.
module mscs_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        stream_byte,
    output logic              push,
    output mscs_pkg::token_t  push_tok
);
    import mscs_pkg::*;

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_CODE,
        PH_CAPTURE,
        PH_SPARE
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [1:0] zero_run_reg, zero_run_next;
    logic [2:0] left_reg, left_next;

    always_comb
    begin
        phase_next    = phase_reg;
        zero_run_next = zero_run_reg;
        left_next     = left_reg;
        push          = 1'b0;
        push_tok.tag  = TOK_HDR;
        push_tok.data = stream_byte;
        if (accept)
        begin
            case (phase_reg)
                PH_CODE:
                begin
                    zero_run_next = 2'd0;
                    push          = 1'b1;
                    if (stream_byte == CODE_SEQ || stream_byte == CODE_PICTURE)
                    begin
                        left_next    = (stream_byte == CODE_SEQ) ? SEQ_HDR_BYTES
                                                                 : PIC_HDR_BYTES;
                        phase_next   = PH_CAPTURE;
                        push_tok.tag = TOK_CODE_HDR;
                    end
                    else
                    begin
                        phase_next   = PH_SEARCH;
                        push_tok.tag = TOK_CODE_DONE;
                    end
                end
                PH_CAPTURE:
                begin
                    push = 1'b1;
                    if (left_reg > 3'd1)
                    begin
                        left_next    = left_reg - 3'd1;
                        push_tok.tag = TOK_HDR;
                    end
                    else
                    begin
                        left_next     = 3'd0;
                        phase_next    = PH_SEARCH;
                        zero_run_next = 2'd0;
                        push_tok.tag  = TOK_LAST;
                    end
                end
                default:
                begin
                    // searching; the spare phase falls back to the search
                    phase_next = PH_SEARCH;
                    if (stream_byte == 8'h00)
                    begin
                        if (zero_run_reg < 2'd2)
                            zero_run_next = zero_run_reg + 2'd1;
                    end
                    else if (stream_byte == PREFIX_END && zero_run_reg >= 2'd2)
                    begin
                        zero_run_next = 2'd0;
                        phase_next    = PH_CODE;
                    end
                    else
                        zero_run_next = 2'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SEARCH;
            zero_run_reg <= 2'd0;
            left_reg     <= 3'd0;
        end
        else
        begin
            phase_reg    <= phase_next;
            zero_run_reg <= zero_run_next;
            left_reg     <= left_next;
        end
    end

endmodule

[rtl/mscs_fifo.sv]
`timescale 1ns / 1ps
// Small token queue between front and back, built from flip-flops.
// Depends on mscs_pkg for the token type.
module mscs_fifo #(
    parameter int Depth = mscs_pkg::QueueDepthDefault
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mscs_pkg::token_t  push_tok,
    input  logic              pop,
    output mscs_pkg::token_t  head_tok,
    output logic              full,
    output logic              empty
);
    import mscs_pkg::*;

    localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    token_t            mem_reg [Depth];
    logic [IdxW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0]   count_reg;
    logic              do_push, do_pop;

    assign full     = (count_reg == CntW'(Depth));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_tok = mem_reg[rd_ptr_reg];

    function automatic logic [IdxW-1:0] bump(input logic [IdxW-1:0] p);
        return (p == IdxW'(Depth - 1)) ? '0 : p + IdxW'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_tok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= bump(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= bump(rd_ptr_reg);
            if (do_push && !do_pop)
                count_reg <= count_reg + CntW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CntW'(1);
        end
    end

endmodule

[rtl/mscs_back.sv]
`timescale 1ns / 1ps
// Back end: assembles header bytes and builds results in an output register.
// Depends on mscs_pkg; drains the token queue.
module mscs_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tok_valid,
    input  mscs_pkg::token_t  tok,
    output logic              tok_pop,
    output logic              unit_valid,
    input  logic              unit_ready,
    output logic [3:0]        unit_kind,
    output logic [7:0]        start_code_value,
    output logic [11:0]       picture_width,
    output logic [11:0]       picture_height,
    output logic [3:0]        rate_code,
    output logic              rate_code_valid,
    output logic [2:0]        coding_type,
    output logic              coding_type_valid
);
    import mscs_pkg::*;

    logic        valid_reg;
    logic [7:0]  pending_reg;
    logic [23:0] cap_reg;
    logic [3:0]  kind_reg, kind_next;
    logic [7:0]  code_reg, code_next;
    logic [11:0] width_reg, width_next, height_reg, height_next;
    logic [3:0]  rate_reg, rate_next;
    logic        rate_ok_reg, rate_ok_next;
    logic [2:0]  ctype_reg, ctype_next;
    logic        ctype_ok_reg, ctype_ok_next;
    logic        emits, slot_free;

    assign emits     = (tok.tag == TOK_CODE_DONE) || (tok.tag == TOK_LAST);
    assign slot_free = !valid_reg || unit_ready;
    assign tok_pop   = tok_valid && (!emits || slot_free);

    always_comb
    begin
        kind_next     = KIND_UNKNOWN;
        code_next     = tok.data;
        width_next    = 12'd0;
        height_next   = 12'd0;
        rate_next     = 4'd0;
        rate_ok_next  = 1'b0;
        ctype_next    = 3'd0;
        ctype_ok_next = 1'b0;
        case (tok.tag)
            TOK_LAST:
            begin
                code_next = pending_reg;
                if (pending_reg == CODE_SEQ)
                begin
                    kind_next    = KIND_SEQ;
                    width_next   = cap_reg[23:12];
                    height_next  = cap_reg[11:0];
                    rate_next    = tok.data[3:0];
                    rate_ok_next = (tok.data[3:0] >= 4'd1) && (tok.data[3:0] <= 4'd8);
                end
                else
                begin
                    // any other pending code finishes as a picture
                    kind_next     = KIND_PICTURE;
                    ctype_next    = tok.data[5:3];
                    ctype_ok_next = (tok.data[5:3] >= 3'd1) && (tok.data[5:3] <= 3'd3);
                end
            end
            default:
                kind_next = classify(tok.data);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (tok_pop)
        begin
            case (tok.tag)
                TOK_CODE_HDR:
                begin
                    pending_reg <= tok.data;
                    cap_reg     <= 24'd0;
                end
                TOK_HDR:
                    cap_reg <= {cap_reg[15:0], tok.data};
                default:
                    cap_reg <= cap_reg;
            endcase
            if (emits)
            begin
                kind_reg     <= kind_next;
                code_reg     <= code_next;
                width_reg    <= width_next;
                height_reg   <= height_next;
                rate_reg     <= rate_next;
                rate_ok_reg  <= rate_ok_next;
                ctype_reg    <= ctype_next;
                ctype_ok_reg <= ctype_ok_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (tok_pop && emits)
            valid_reg <= 1'b1;
        else if (unit_ready)
            valid_reg <= 1'b0;
    end

    assign unit_valid        = valid_reg;
    assign unit_kind         = kind_reg;
    assign start_code_value  = code_reg;
    assign picture_width     = width_reg;
    assign picture_height    = height_reg;
    assign rate_code         = rate_reg;
    assign rate_code_valid   = rate_ok_reg;
    assign coding_type       = ctype_reg;
    assign coding_type_valid = ctype_ok_reg;

endmodule

[rtl/mpeg_start_code_scanner_unit.sv]
`timescale 1ns / 1ps
// MPEG start code scanner: one stream byte per cycle in while stream_ready is high, one unit record out.
// The completing byte is registered in the token queue, then in the back end's output register that drives unit_valid.
// Throughput: one byte per cycle while stream_ready is high, set by the front state machine;
// the QueueDepth-entry token queue absorbs result stalls before stream_ready drops.
// Reset (rst_n low, async): search restarts, queue empties, no result pending.
// Depends on mscs_pkg, mscs_front, mscs_fifo, mscs_back.
module mpeg_start_code_scanner_unit #(
    parameter int QueueDepth = mscs_pkg::QueueDepthDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        stream_valid,
    output logic        stream_ready,
    input  logic [7:0]  stream_byte,
    output logic        unit_valid,
    input  logic        unit_ready,
    output logic [3:0]  unit_kind,
    output logic [7:0]  start_code_value,
    output logic [11:0] picture_width,
    output logic [11:0] picture_height,
    output logic [3:0]  rate_code,
    output logic        rate_code_valid,
    output logic [2:0]  coding_type,
    output logic        coding_type_valid
);
    import mscs_pkg::*;

    logic   accept, q_push, q_pop, q_full, q_empty;
    token_t push_tok, head_tok;

    assign stream_ready = !q_full;
    assign accept       = stream_valid && stream_ready;

    mscs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .stream_byte (stream_byte),
        .push        (q_push),
        .push_tok    (push_tok)
    );

    mscs_fifo #(
        .Depth (QueueDepth)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_tok (push_tok),
        .pop      (q_pop),
        .head_tok (head_tok),
        .full     (q_full),
        .empty    (q_empty)
    );

    mscs_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .tok_valid         (!q_empty),
        .tok               (head_tok),
        .tok_pop           (q_pop),
        .unit_valid        (unit_valid),
        .unit_ready        (unit_ready),
        .unit_kind         (unit_kind),
        .start_code_value  (start_code_value),
        .picture_width     (picture_width),
        .picture_height    (picture_height),
        .rate_code         (rate_code),
        .rate_code_valid   (rate_code_valid),
        .coding_type       (coding_type),
        .coding_type_valid (coding_type_valid)
    );

    a_rate_only_seq: assert property (@(posedge clk) disable iff (!rst_n)
        unit_valid && rate_code_valid |-> unit_kind == KIND_SEQ)
        else $error("rate code flagged valid on a non-sequence unit");

    a_ctype_only_pic: assert property (@(posedge clk) disable iff (!rst_n)
        unit_valid && coding_type_valid |-> unit_kind == KIND_PICTURE)
        else $error("coding type flagged valid on a non-picture unit");

    a_size_only_seq: assert property (@(posedge clk) disable iff (!rst_n)
        unit_valid && unit_kind != KIND_SEQ |->
            picture_width == 12'd0 && picture_height == 12'd0 && rate_code == 4'd0)
        else $error("sequence fields nonzero on another unit kind");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && head_tok.tag == TOK_LAST |-> !unit_valid || unit_ready)
        else $error("back end overwrote an untaken result");

endmodule
